// File: rtl/ogrc_pkg.sv
// ogrc_pkg: shared types, codes and constants of the occupancy grid ray caster
// used by ogrc_norm and occupancy_grid_ray_cast; depends on nothing
package ogrc_pkg;

  localparam int unsigned GRID_DIM_DEF  = 256;
  localparam int unsigned CELL_BITS_DEF = 8;
  localparam int unsigned MAX_STEPS     = 512;
  localparam int unsigned CROSS_N       = 5;

  // register indexes of the config port
  localparam logic [7:0] CFG_MAP_COLS = 8'd0;
  localparam logic [7:0] CFG_MAP_ROWS = 8'd1;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_SAME = 2'd2
  } status_e;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [7:0]  cell_value;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] target_x;
    logic [15:0] target_y;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [8:0]  distance;
  } out_t;

  // direction handed to the normalizer
  typedef struct packed {
    logic        dx_neg;
    logic [15:0] dx_mag;
    logic        dy_neg;
    logic [15:0] dy_mag;
  } norm_req_t;

  // unit vector, signed q2.14
  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
  } norm_res_t;

  // cross offsets: left, center, up, down, right
  function automatic logic signed [1:0] cross_ox(input logic [2:0] k);
    logic signed [1:0] o;
    case (k)
      3'd0:    o = -2'sd1;
      3'd4:    o = 2'sd1;
      default: o = 2'sd0;
    endcase
    return o;
  endfunction

  function automatic logic signed [1:0] cross_oy(input logic [2:0] k);
    logic signed [1:0] o;
    case (k)
      3'd2:    o = 2'sd1;
      3'd3:    o = -2'sd1;
      default: o = 2'sd0;
    endcase
    return o;
  endfunction

endpackage

// File: rtl/occupancy_grid_ray_cast.sv
// occupancy_grid_ray_cast: grid write and ray cast, one word at a time
// cell write: written to the grid port when taken; cast: normalization (29 root
// steps and two 16-step divisions), then per march step five reads on the
// single grid port plus one evaluate, for up to 512 steps
// after reset a clearing pass zeroes the grid, with no word taken until it ends;
// config writes are taken at any time, registers reset to 256
// depends on ogrc_pkg, ogrc_ram, ogrc_norm
module occupancy_grid_ray_cast #(
  parameter int unsigned GRID_DIM  = ogrc_pkg::GRID_DIM_DEF,
  parameter int unsigned CELL_BITS = ogrc_pkg::CELL_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ogrc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ogrc_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_index_i,
  input  logic [8:0]      cfg_data_i
);
  import ogrc_pkg::*;

  localparam int unsigned DEPTH = GRID_DIM * GRID_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = $clog2(GRID_DIM);
  localparam int unsigned CW    = $clog2(GRID_DIM + 1);
  localparam int unsigned PW    = 27;   // q.14 position
  localparam int unsigned CXW   = 15;   // signed cell coordinate
  localparam int unsigned SW    = $clog2(MAX_STEPS + 1);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_NORM  = 5'b00010,
    T_CROSS = 5'b00100,
    T_EVAL  = 5'b01000,
    T_DONE  = 5'b10000
  } tstate_e;

  tstate_e state_q, state_d;

  // config registers
  logic [8:0] map_cols_q, map_rows_q;

  // clearing pass
  logic [AW-1:0] clr_q;
  logic          clr_done_q;

  // march state
  logic signed [PW-1:0] px_q, px_d, py_q, py_d;
  logic signed [15:0]   ux_q, ux_d, uy_q, uy_d;
  logic [SW-1:0]        r_q, r_d;
  logic [2:0]           k_q, k_d;
  logic                 hit_q, hit_d, on_q, on_d, pend_q, pend_d;
  out_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  // limits
  logic [CW-1:0] cols, rows;
  logic [CW:0]   step_sum;
  logic [SW-1:0] steps;

  // direction
  logic [16:0] dx, dy;
  norm_req_t   nreq;
  norm_res_t   nres;
  logic        norm_start, norm_done;

  // cross addressing
  logic signed [CXW-1:0] cx, cy, xk, yk;
  logic                  x_ok, y_ok, onmap, data_hit;

  // grid port
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  logic in_acc, wr_acc, cast_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = clr_done_q && (state_q == T_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign wr_acc      = in_acc && (in_data_i.kind == KIND_WRITE);
  assign cast_acc    = in_acc && (in_data_i.kind == KIND_CAST);

  // extents limited to the grid, step budget capped so the distance fits
  assign cols     = (int'(map_cols_q) < GRID_DIM) ? CW'(map_cols_q) : CW'(GRID_DIM);
  assign rows     = (int'(map_rows_q) < GRID_DIM) ? CW'(map_rows_q) : CW'(GRID_DIM);
  assign step_sum = (CW+1)'(cols) + (CW+1)'(rows);
  assign steps    = (int'(step_sum) > MAX_STEPS) ? SW'(MAX_STEPS) : SW'(step_sum);

  // signed q8.8 direction, split into sign and magnitude
  assign dx          = {1'b0, in_data_i.target_x} - {1'b0, in_data_i.start_x};
  assign dy          = {1'b0, in_data_i.target_y} - {1'b0, in_data_i.start_y};
  assign nreq.dx_neg = dx[16];
  assign nreq.dx_mag = dx[16] ? 16'(-dx) : dx[15:0];
  assign nreq.dy_neg = dy[16];
  assign nreq.dy_mag = dy[16] ? 16'(-dy) : dy[15:0];
  assign norm_start  = cast_acc && (dx != '0 || dy != '0);

  ogrc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .req_i   (nreq),
    .done_o  (norm_done),
    .res_o   (nres)
  );

  // round half away from zero to a cell
  function automatic logic signed [CXW-1:0] round_cell(input logic signed [PW-1:0] p);
    logic [PW-1:0]  mag;
    logic [CXW-1:0] c;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    c   = CXW'((mag + PW'(8192)) >> 14);
    return p[PW-1] ? CXW'(-c) : c;
  endfunction

  assign cx    = round_cell(px_q);
  assign cy    = round_cell(py_q);
  assign xk    = cx + CXW'(cross_ox(k_q));
  assign yk    = cy + CXW'(cross_oy(k_q));
  assign x_ok  = !xk[CXW-1] && (xk[CXW-2:0] < (CXW-1)'(cols));
  assign y_ok  = !yk[CXW-1] && (yk[CXW-2:0] < (CXW-1)'(rows));
  assign onmap = x_ok && y_ok;
  // data of the previous cycle's read, if it was on the map
  assign data_hit = pend_q && (ram_rdata != '0);

  // grid port: clearing pass, then cell writes or cross reads
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = AW'(yk[IW-1:0]) * AW'(GRID_DIM) + AW'(xk[IW-1:0]);
    if (!clr_done_q) begin
      ram_we   = 1'b1;
      ram_addr = clr_q;
    end else if (wr_acc) begin
      ram_we    = (int'(in_data_i.cell_x) < GRID_DIM) && (int'(in_data_i.cell_y) < GRID_DIM);
      ram_addr  = AW'(in_data_i.cell_y) * AW'(GRID_DIM) + AW'(in_data_i.cell_x);
      ram_wdata = CELL_BITS'(in_data_i.cell_value);
    end
  end

  ogrc_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    r_d         = r_q;
    k_d         = k_q;
    hit_d       = hit_q;
    on_d        = on_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      T_IDLE: begin
        if (cast_acc) begin
          px_d  = PW'({in_data_i.start_x, 6'b0});
          py_d  = PW'({in_data_i.start_y, 6'b0});
          r_d   = '0;
          k_d   = '0;
          if (norm_start) begin
            state_d = T_NORM;
          end else begin
            res_d.status   = ST_SAME;
            res_d.distance = '0;
            state_d        = T_DONE;
          end
        end
      end
      T_NORM: begin
        if (norm_done) begin
          ux_d = nres.ux;
          uy_d = nres.uy;
          if (steps == '0) begin
            res_d.status   = ST_MISS;
            res_d.distance = '0;
            state_d        = T_DONE;
          end else begin
            state_d = T_CROSS;
          end
        end
      end
      T_CROSS: begin
        // issue one cross read per cycle, check the one before
        pend_d = onmap;
        if (k_q == '0) begin
          hit_d = 1'b0;
          on_d  = onmap;
        end else begin
          hit_d = hit_q || data_hit;
          on_d  = on_q || onmap;
        end
        if (k_q == 3'(CROSS_N - 1)) begin
          state_d = T_EVAL;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      T_EVAL: begin
        k_d = '0;
        if (!on_q) begin
          // whole cross off the map
          res_d.status   = ST_MISS;
          res_d.distance = '0;
          state_d        = T_DONE;
        end else if (hit_q || data_hit) begin
          res_d.status   = ST_HIT;
          res_d.distance = 9'(r_q);
          state_d        = T_DONE;
        end else if (r_q + SW'(1) >= steps) begin
          res_d.status   = ST_MISS;
          res_d.distance = '0;
          state_d        = T_DONE;
        end else begin
          r_d     = r_q + SW'(1);
          px_d    = px_q + PW'(ux_q);
          py_d    = py_q + PW'(uy_q);
          state_d = T_CROSS;
        end
      end
      T_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      clr_done_q  <= 1'b0;
      map_cols_q  <= 9'd256;
      map_rows_q  <= 9'd256;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (!clr_done_q) begin
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_done_q <= 1'b1;
        end else begin
          clr_q <= clr_q + AW'(1);
        end
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MAP_COLS) begin
          map_cols_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_MAP_ROWS) begin
          map_rows_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    ux_q  <= ux_d;
    uy_q  <= uy_d;
    r_q   <= r_d;
    k_q   <= k_d;
    hit_q <= hit_d;
    on_q  <= on_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/ogrc_ram.sv
// ogrc_ram: generic single port ram, registered read
// no dependencies
module ogrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ogrc_norm.sv
// ogrc_norm: turns a direction into a q2.14 unit vector
// squares by one multiplier, digit-serial square root, shared restoring divider
// depends on ogrc_pkg
module ogrc_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ogrc_pkg::norm_req_t req_i,
  output logic               done_o,
  output ogrc_pkg::norm_res_t res_o
);
  import ogrc_pkg::*;

  localparam int unsigned SUM_W     = 33;
  localparam int unsigned FRAC_SH   = 24;
  localparam int unsigned VW        = 58;          // even width holding sum << 24
  localparam int unsigned ROOT_W    = VW / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned NUM_W     = 43;          // (mag << 26) + len/2
  localparam int unsigned QUO_W     = 16;

  typedef enum logic [6:0] {
    N_IDLE = 7'b0000001,
    N_SQX  = 7'b0000010,
    N_SQY  = 7'b0000100,
    N_SUM  = 7'b0001000,
    N_SQRT = 7'b0010000,
    N_DSET = 7'b0100000,
    N_DIV  = 7'b1000000
  } nstate_e;

  nstate_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  norm_req_t req_q;
  logic [31:0] prod_q;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [VW-1:0] vsh_q, vsh_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W-1:0] drem_q, drem_d;
  logic [QUO_W-1:0] nsh_q, nsh_d, quo_q, quo_d;
  logic ovf_q, ovf_d, sel_q, sel_d, done_q, done_d;
  norm_res_t res_q, res_d;

  logic [15:0] mul_a;
  logic [REM_W+1:0] rem_sh, trial;
  logic [15:0] div_mag;
  logic [NUM_W-1:0] num;
  logic [ROOT_W:0] dsh;
  logic [QUO_W-1:0] quo_fin;
  logic div_neg, sat;
  logic [16:0] mag_fin;
  logic signed [15:0] comp_fin;

  assign mul_a   = (state_q == N_SQX) ? req_q.dx_mag : req_q.dy_mag;
  assign rem_sh  = {rem_q, vsh_q[VW-1 -: 2]};
  assign trial   = (REM_W+2)'({root_q, 2'b01});
  assign div_mag = sel_q ? req_q.dy_mag : req_q.dx_mag;
  assign div_neg = sel_q ? req_q.dy_neg : req_q.dx_neg;
  assign num     = (NUM_W'(div_mag) << 26) + NUM_W'(root_q >> 1);
  assign dsh     = {drem_q, nsh_q[QUO_W-1]};
  assign quo_fin = (dsh >= {1'b0, root_q}) ? {quo_q[QUO_W-2:0], 1'b1} : {quo_q[QUO_W-2:0], 1'b0};
  // quotient above 32767 saturates, to 32768 on the negative side
  assign sat      = ovf_q || quo_fin[QUO_W-1];
  assign mag_fin  = sat ? (div_neg ? 17'd32768 : 17'd32767) : {1'b0, quo_fin};
  assign comp_fin = div_neg ? 16'(-mag_fin) : 16'(mag_fin);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    vsh_d   = vsh_q;
    rem_d   = rem_q;
    root_d  = root_q;
    drem_d  = drem_q;
    nsh_d   = nsh_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    sel_d   = sel_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          state_d = N_SQX;
        end
      end
      N_SQX: begin
        state_d = N_SQY;
      end
      N_SQY: begin
        acc_d   = SUM_W'(prod_q);
        state_d = N_SUM;
      end
      N_SUM: begin
        acc_d   = acc_q + SUM_W'(prod_q);
        state_d = N_SQRT;
        vsh_d   = VW'({acc_q + SUM_W'(prod_q), FRAC_SH'(0)});
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = 5'(ROOT_W - 1);
      end
      N_SQRT: begin
        // one root bit per cycle
        if (rem_sh >= trial) begin
          rem_d  = REM_W'(rem_sh - trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(rem_sh);
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        vsh_d = vsh_q << 2;
        if (cnt_q == '0) begin
          state_d = N_DSET;
          sel_d   = 1'b0;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      N_DSET: begin
        ovf_d   = ROOT_W'(num[NUM_W-1:QUO_W]) >= root_q;
        drem_d  = ROOT_W'(num[NUM_W-1:QUO_W]);
        nsh_d   = num[QUO_W-1:0];
        quo_d   = '0;
        cnt_d   = 5'(QUO_W - 1);
        state_d = N_DIV;
      end
      N_DIV: begin
        // one quotient bit per cycle
        if (dsh >= {1'b0, root_q}) begin
          drem_d = ROOT_W'(dsh - {1'b0, root_q});
        end else begin
          drem_d = ROOT_W'(dsh);
        end
        quo_d = quo_fin;
        nsh_d = nsh_q << 1;
        if (cnt_q == '0) begin
          if (sel_q) begin
            res_d.uy = comp_fin;
            done_d   = 1'b1;
            state_d  = N_IDLE;
          end else begin
            res_d.ux = comp_fin;
            sel_d    = 1'b1;
            state_d  = N_DSET;
          end
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == N_IDLE && start_i) begin
      req_q <= req_i;
    end
    prod_q <= mul_a * mul_a;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    vsh_q  <= vsh_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    drem_q <= drem_d;
    nsh_q  <= nsh_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    sel_q  <= sel_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
